### sv/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int DIGIT_DEPTH_DEFAULT = 32;

    localparam int RADIX_WIDTH = 6;
    localparam int CHAR_WIDTH  = 7;

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] RADIX_DECIMAL = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] DIGIT_MAX     = 6'd9;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LETTER = 7'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS  = 7'h2d;

    typedef struct packed {
        logic                   done;
        logic                   nonzero;
        logic [RADIX_WIDTH-1:0] remainder;
    } div_status_t;

    function automatic logic [RADIX_WIDTH-1:0] clamp_radix(input logic [RADIX_WIDTH-1:0] r);
        logic [RADIX_WIDTH-1:0] c;
        c = r;
        if (r < RADIX_MIN)
        begin
            c = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            c = RADIX_MAX;
        end
        return c;
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] c;
        if (d > DIGIT_MAX)
        begin
            c = CHAR_LETTER + CHAR_WIDTH'(d - RADIX_DECIMAL);
        end
        else
        begin
            c = CHAR_ZERO + CHAR_WIDTH'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/itoa_serial_divider.sv
`default_nettype none

module itoa_serial_divider #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [VALUE_WIDTH-1:0]           dividend,
    input  wire logic [itoa_pkg::RADIX_WIDTH-1:0] radix,
    output itoa_pkg::div_status_t                 status,
    output logic      [VALUE_WIDTH-1:0]           quotient
);

    localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int RW    = itoa_pkg::RADIX_WIDTH;

    logic [VALUE_WIDTH-1:0] q_reg;
    logic [VALUE_WIDTH-1:0] q_next;
    logic [RW-1:0]          r_reg;
    logic [RW-1:0]          r_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    logic                   nz_reg;
    logic                   nz_next;

    logic [RW:0] partial;
    logic [RW:0] diff;
    logic        fits;

    always_comb
    begin
        partial = {r_reg, q_reg[VALUE_WIDTH-1]};
        fits    = (partial >= {1'b0, radix});
        diff    = partial - {1'b0, radix};

        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        nz_next   = nz_reg;

        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = CNT_W'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
            nz_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[VALUE_WIDTH-2:0], fits};
            r_next   = fits ? diff[RW-1:0] : partial[RW-1:0];
            nz_next  = nz_reg | fits;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            nz_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            nz_reg   <= nz_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign status.done      = done_reg;
    assign status.nonzero   = nz_reg;
    assign status.remainder = r_reg;
    assign quotient         = q_reg;

endmodule

`default_nettype wire

### sv/itoa_digit_store.sv
`default_nettype none

module itoa_digit_store #(
    parameter int DIGIT_DEPTH = itoa_pkg::DIGIT_DEPTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [$clog2(DIGIT_DEPTH)-1:0]         wr_addr,
    input  wire logic [itoa_pkg::CHAR_WIDTH-1:0]        wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [$clog2(DIGIT_DEPTH)-1:0]         rd_addr,
    output logic      [itoa_pkg::CHAR_WIDTH-1:0]        rd_data
);

    logic [itoa_pkg::CHAR_WIDTH-1:0] mem [DIGIT_DEPTH];
    logic [itoa_pkg::CHAR_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/integer_to_ascii_radix.sv
// Conversion: a restoring divider retires one quotient bit per cycle for each digit, and
// for a negative number in radix ten a '-' is stored after the digits. Characters leave
// the store '-' first, then most significant digit first, one character a cycle while
// out_stall is low. A new request is taken only in idle, after the last character is read.
// Reset: asynchronous, active low; clears control and counters, radix returns to ten.
// The digit store holds no reset and is read only where written.
`default_nettype none

module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT,
    parameter int DIGIT_DEPTH = itoa_pkg::DIGIT_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [VALUE_WIDTH-1:0]    number,
    input  wire logic [itoa_pkg::RADIX_WIDTH-1:0] radix,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [itoa_pkg::CHAR_WIDTH-1:0]  char_code,
    output logic                                  last
);

    localparam int ADDR_W = $clog2(DIGIT_DEPTH);
    localparam int CNT_W  = $clog2(DIGIT_DEPTH + 1);
    localparam int RW     = itoa_pkg::RADIX_WIDTH;
    localparam int CW     = itoa_pkg::CHAR_WIDTH;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIVIDE = 2'd1;
    localparam logic [1:0] ST_SIGN   = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] digit_count_reg;
    logic [CNT_W-1:0] digit_count_next;
    logic [RW-1:0]    radix_reg;
    logic [RW-1:0]    radix_next;
    logic             negative_flag_reg;
    logic             negative_flag_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             last_reg;
    logic             last_next;

    logic                   in_accept;
    logic                   slot_free;
    logic [RW-1:0]          radix_clamped;
    logic                   is_negative;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [CNT_W-1:0]       count_minus;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    itoa_pkg::div_status_t  div_status;
    logic [VALUE_WIDTH-1:0] div_quotient;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CW-1:0]     wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        radix_clamped = itoa_pkg::clamp_radix(radix);
        is_negative   = number[VALUE_WIDTH-1] && (radix_clamped == itoa_pkg::RADIX_DECIMAL);
        magnitude     = is_negative ? (VALUE_WIDTH'(0) - $unsigned(number)) : $unsigned(number);
        count_minus   = digit_count_reg - CNT_W'(1);

        state_next         = state_reg;
        digit_count_next   = digit_count_reg;
        radix_next         = radix_reg;
        negative_flag_next = negative_flag_reg;
        last_next          = last_reg;
        out_valid_next     = out_valid_reg && out_stall;

        div_start    = 1'b0;
        div_dividend = div_quotient;
        wr_en        = 1'b0;
        wr_addr      = digit_count_reg[ADDR_W-1:0];
        wr_data      = itoa_pkg::digit_char(div_status.remainder);
        rd_en        = 1'b0;
        rd_addr      = count_minus[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    radix_next         = radix_clamped;
                    negative_flag_next = is_negative;
                    digit_count_next   = '0;
                    div_start          = 1'b1;
                    div_dividend       = magnitude;
                    state_next         = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    if (digit_count_reg < CNT_W'(DIGIT_DEPTH))
                    begin
                        wr_en            = 1'b1;
                        digit_count_next = digit_count_reg + CNT_W'(1);
                    end
                    if (div_status.nonzero)
                    begin
                        div_start = 1'b1;
                    end
                    else if (negative_flag_reg)
                    begin
                        state_next = ST_SIGN;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SIGN:
            begin
                wr_data = itoa_pkg::CHAR_MINUS;
                if (digit_count_reg < CNT_W'(DIGIT_DEPTH))
                begin
                    wr_en            = 1'b1;
                    digit_count_next = digit_count_reg + CNT_W'(1);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    rd_en            = 1'b1;
                    out_valid_next   = 1'b1;
                    last_next        = (digit_count_reg == CNT_W'(1));
                    digit_count_next = count_minus;
                    if (digit_count_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            digit_count_reg   <= '0;
            radix_reg         <= itoa_pkg::RADIX_DECIMAL;
            negative_flag_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            last_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            digit_count_reg   <= digit_count_next;
            radix_reg         <= radix_next;
            negative_flag_reg <= negative_flag_next;
            out_valid_reg     <= out_valid_next;
            last_reg          <= last_next;
        end
    end

    itoa_serial_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .radix    (radix_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    itoa_digit_store #(
        .DIGIT_DEPTH(DIGIT_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (char_code)
    );

    assign out_valid = out_valid_reg;
    assign last      = last_reg;

    // hold the character count within the store
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= CNT_W'(DIGIT_DEPTH))
        else $error("digit count beyond store depth");

    // drain only a nonempty store
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (digit_count_reg != '0))
        else $error("emit with empty store");

    // return to idle after the final character leaves the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && (digit_count_reg == CNT_W'(1))) |=> (state_reg == ST_IDLE) && last_reg)
        else $error("final character not flagged");

    // start the divider on every accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_DIVIDE) && !div_status.done)
        else $error("request accepted without a division");

endmodule

`default_nettype wire

### sim/integer_to_ascii_radix_checker.sv
`timescale 1ns / 100ps

module integer_to_ascii_radix_checker
    import itoa_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic signed [VALUE_WIDTH_DEFAULT-1:0] number,
    input  wire logic [RADIX_WIDTH-1:0]        radix,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [CHAR_WIDTH-1:0]         char_code,
    input  wire logic                          last,
    output int                                 mismatch_count,
    output int                                 chars_pending,
    output int                                 chars_seen
);

    localparam int VW = VALUE_WIDTH_DEFAULT;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] code;
        logic                  is_last;
    } char_result_t;

    char_result_t expected_chars[$];

    initial
    begin
        mismatch_count = 0;
        chars_seen     = 0;
    end

    assign chars_pending = expected_chars.size();

    // Build the digit string least significant first, then queue it in emission order.
    function automatic void predict_chars(input logic [VW-1:0] value,
                                          input logic [RADIX_WIDTH-1:0] base_raw);
        logic [RADIX_WIDTH-1:0] base;
        logic [VW-1:0]          magnitude;
        logic [RADIX_WIDTH-1:0] digit;
        logic                   minus;
        logic [CHAR_WIDTH-1:0]  reversed[$];
        char_result_t           item;
        base = base_raw;
        if (base_raw < RADIX_MIN)
        begin
            base = RADIX_MIN;
        end
        else if (base_raw > RADIX_MAX)
        begin
            base = RADIX_MAX;
        end
        minus     = value[VW-1] && (base == RADIX_DECIMAL);
        magnitude = minus ? VW'(-value) : value;
        if (magnitude == '0)
        begin
            reversed.push_back(CHAR_ZERO);
        end
        while (magnitude != '0)
        begin
            digit = RADIX_WIDTH'(magnitude % VW'(base));
            if (digit > DIGIT_MAX)
            begin
                reversed.push_back(CHAR_LETTER + CHAR_WIDTH'(digit - RADIX_DECIMAL));
            end
            else
            begin
                reversed.push_back(CHAR_ZERO + CHAR_WIDTH'(digit));
            end
            magnitude = magnitude / VW'(base);
        end
        if (minus)
        begin
            reversed.push_back(CHAR_MINUS);
        end
        for (int k = reversed.size() - 1; k >= 0; k--)
        begin
            item.code    = reversed[k];
            item.is_last = (k == 0);
            expected_chars.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin
        char_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                chars_seen++;
                if (expected_chars.size() == 0)
                begin
                    $error("char_code: expected none, actual %h", char_code);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_code !== want.code)
                    begin
                        $error("char_code: expected %h, actual %h", want.code, char_code);
                        mismatch_count++;
                    end
                    if (last !== want.is_last)
                    begin
                        $error("last: expected %b, actual %b", want.is_last, last);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_chars(number, radix);
            end
        end
    end

endmodule

### sim/integer_to_ascii_radix_tb.sv
`timescale 1ns / 100ps

module integer_to_ascii_radix_tb;

    import itoa_pkg::*;

    localparam int VW               = VALUE_WIDTH_DEFAULT;
    localparam int RANDOM_REQUESTS  = 200;
    localparam int QUIET_REQUESTS   = 30;
    localparam int CYCLE_LIMIT      = 1500000;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES     = 64;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic signed [VW-1:0]   number    = '0;
    logic [RADIX_WIDTH-1:0] radix     = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [CHAR_WIDTH-1:0]  char_code;
    logic                   last;

    bit   idle_on      = 1'b1;
    bit   hold_off_go  = 1'b0;
    logic long_hold    = 1'b0;
    int   stall_burst  = 0;
    int   cycle_count  = 0;
    int   requests_sent = 0;
    int   mismatch_count;
    int   chars_pending;
    int   chars_seen;

    always #5 clk = ~clk;

    integer_to_ascii_radix i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number    (number),
        .radix     (radix),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last)
    );

    integer_to_ascii_radix_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .number         (number),
        .radix          (radix),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_code      (char_code),
        .last           (last),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending),
        .chars_seen     (chars_seen)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_burst != 0)
        begin
            stall_burst <= stall_burst - 1;
            out_stall   <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_burst <= $urandom_range(0, 15);
            out_stall   <= 1'b1;
        end
        else
        begin
            out_stall <= long_hold;
        end
    end

    // Hold the output off long enough for the block to fill and stall its input.
    initial
    begin
        int held;
        wait (hold_off_go);
        @(posedge clk);
        long_hold <= 1'b1;
        for (held = 0; held < LONG_HOLD_CYCLES; held++)
        begin
            @(posedge clk);
        end
        long_hold <= 1'b0;
    end

    task automatic send_request(input logic signed [VW-1:0] value,
                                input logic [RADIX_WIDTH-1:0] base);
        int gap;
        number   <= value;
        radix    <= base;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        requests_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic signed [VW-1:0]   value;
        logic [RADIX_WIDTH-1:0] base;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(32'sd0, RADIX_DECIMAL);
        send_request(32'sd0, RADIX_MIN);
        send_request(32'sh7fff_ffff, RADIX_MIN);
        send_request(-32'sd1, RADIX_MIN);
        send_request(32'sh8000_0000, RADIX_DECIMAL);
        send_request(32'sh8000_0000, 6'd16);
        send_request(32'sh7fff_ffff, RADIX_DECIMAL);
        send_request(-32'sd1, RADIX_DECIMAL);
        send_request(-32'sd1, RADIX_MAX);
        send_request(-32'sd123456789, RADIX_DECIMAL);
        send_request(-32'sd123456789, 6'd8);
        send_request(32'sd12345, 6'd0);
        send_request(32'sd12345, 6'd1);
        send_request(32'sd255, 6'd63);
        send_request(32'sd35, 6'd37);
        send_request(32'sd35, RADIX_MAX);
        send_request(32'sd10, 6'd11);
        send_request(32'sd9, RADIX_DECIMAL);
        send_request(32'sd1, RADIX_MAX);
        send_request(32'sh5555_5555, 6'd3);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 20)
            begin
                hold_off_go = 1'b1;
            end
            if (i == RANDOM_REQUESTS - QUIET_REQUESTS)
            begin
                idle_on = 1'b0;
            end
            case ($urandom_range(0, 5))
                0: value = $urandom_range(0, 40);
                1: value = 32'sd0 - $urandom_range(1, 1000);
                2: value = $urandom >> $urandom_range(0, 31);
                3: value = $urandom | 32'h8000_0000;
                default: value = $urandom;
            endcase
            if ($urandom_range(0, 4) == 0)
            begin
                base = RADIX_WIDTH'($urandom_range(0, 63));
            end
            else
            begin
                base = RADIX_WIDTH'($urandom_range(2, 36));
            end
            send_request(value, base);
        end
        in_valid <= 1'b0;

        while (chars_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d numbers into %0d characters over radix codes 0 to 63,",
                 requests_sent, chars_seen);
        $display("including signed extremes, clamped bases and a long output hold-off.");
        if (mismatch_count == 0 && chars_pending == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
sv/itoa_pkg.sv
sv/itoa_serial_divider.sv
sv/itoa_digit_store.sv
sv/integer_to_ascii_radix.sv
sim/integer_to_ascii_radix_checker.sv
sim/integer_to_ascii_radix_tb.sv
